/* rtl/hcbd_pkg.sv */
`default_nettype none

package hcbd_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] end_status_t;

  // end status codes
  localparam end_status_t ST_TERMINAL  = 2'd0;
  localparam end_status_t ST_EARLY_END = 2'd1;
  localparam end_status_t ST_TRUNCATED = 2'd2;
  localparam end_status_t ST_BAD_SIZE  = 2'd3;

  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_LF    = 8'h0a;
  localparam byte_t CH_VT    = 8'h0b;
  localparam byte_t CH_FF    = 8'h0c;
  localparam byte_t CH_CR    = 8'h0d;
  localparam byte_t CH_SPACE = 8'h20;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input byte_t c);
    hex_digit_t d;
    d.ok    = 1'b0;
    d.value = 4'd0;
    if (c >= "0" && c <= "9") begin
      d.ok    = 1'b1;
      d.value = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      d.ok    = 1'b1;
      d.value = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      d.ok    = 1'b1;
      d.value = 4'(c - "A" + 8'd10);
    end
    return d;
  endfunction

  function automatic logic is_blank(input byte_t c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

`default_nettype wire

/* rtl/hcbd_in_if.sv */
`default_nettype none

interface hcbd_in_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           byte_in;
  logic                 last_in;

  modport source (output valid, output byte_in, output last_in, input ready);
  modport sink   (input valid, input byte_in, input last_in, output ready);
endinterface

`default_nettype wire

/* rtl/hcbd_out_if.sv */
`default_nettype none

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       data_valid;
  logic       end_of_message;
  logic [1:0] end_status;

  modport source (output valid, output byte_out, output data_valid,
                  output end_of_message, output end_status, input ready);
  modport sink   (input valid, input byte_out, input data_valid,
                  input end_of_message, input end_status, output ready);
endinterface

`default_nettype wire

/* rtl/http_chunked_body_decoder.sv */
// channel   dir  payload                                        handshake
// in_ch     in   byte_in[7:0], last_in                          valid/ready
// out_ch    out  byte_out[7:0], data_valid, end_of_message,     valid/ready
//                end_status[1:0]
//
// one byte per clock: the parser state updates in the cycle a byte is taken
// and any result lands in a single output register in the cycle after.
// a byte is taken whenever the output register is empty or is being drained.
// out_ch.ready low holds the result and stalls the input only when full.
// rst_n is synchronous, active low; a byte with last_in also returns the
// parser to its reset state.
`default_nettype none

module http_chunked_body_decoder #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hcbd_in_if.sink    in_ch,
  hcbd_out_if.source out_ch
);

  import hcbd_pkg::*;

  typedef enum logic [1:0] {
    PH_SIZE,
    PH_DATA,
    PH_SKIP,
    PH_STOP
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] size_acc_r, size_acc_nxt;
  logic                 digit_seen_r, digit_seen_nxt;
  logic                 digits_closed_r, digits_closed_nxt;
  logic                 cr_pending_r, cr_pending_nxt;
  logic [SIZE_BITS-1:0] bytes_rem_r, bytes_rem_nxt;
  logic [1:0]           skip_cnt_r, skip_cnt_nxt;
  end_status_t          stop_status_r, stop_status_nxt;

  logic        out_valid_r;
  byte_t       out_byte_r;
  logic        out_dv_r;
  logic        out_eom_r;
  end_status_t out_status_r;

  logic        in_fire;
  logic        emit;
  logic        emit_dv;
  end_status_t emit_status;
  hex_digit_t  hd;
  byte_t       c;

  assign c       = in_ch.byte_in;
  assign hd      = hex_decode(c);
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    phase_nxt         = phase_r;
    size_acc_nxt      = size_acc_r;
    digit_seen_nxt    = digit_seen_r;
    digits_closed_nxt = digits_closed_r;
    cr_pending_nxt    = cr_pending_r;
    bytes_rem_nxt     = bytes_rem_r;
    skip_cnt_nxt      = skip_cnt_r;
    stop_status_nxt   = stop_status_r;
    emit_dv           = 1'b0;

    case (phase_r)
      PH_SIZE: begin
        if (cr_pending_r && c == CH_LF) begin
          if (!digit_seen_r) begin
            phase_nxt       = PH_STOP;
            stop_status_nxt = ST_BAD_SIZE;
          end else if (size_acc_r == '0) begin
            phase_nxt       = PH_STOP;
            stop_status_nxt = ST_TERMINAL;
          end else begin
            bytes_rem_nxt = size_acc_r;
            phase_nxt     = PH_DATA;
          end
          size_acc_nxt      = '0;
          digit_seen_nxt    = 1'b0;
          digits_closed_nxt = 1'b0;
          cr_pending_nxt    = 1'b0;
        end else begin
          cr_pending_nxt = (c == CH_CR);
          if (!digits_closed_r) begin
            if (hd.ok) begin
              // another digit would shift bits out of the size
              if (size_acc_r[SIZE_BITS-1 -: 4] != 4'd0) begin
                phase_nxt       = PH_STOP;
                stop_status_nxt = ST_BAD_SIZE;
              end else begin
                size_acc_nxt   = {size_acc_r[SIZE_BITS-5:0], hd.value};
                digit_seen_nxt = 1'b1;
              end
            end else if (digit_seen_r || !is_blank(c)) begin
              digits_closed_nxt = 1'b1;
            end
          end
        end
      end
      PH_DATA: begin
        emit_dv       = 1'b1;
        bytes_rem_nxt = bytes_rem_r - SIZE_BITS'(1);
        if (bytes_rem_r == SIZE_BITS'(1)) begin
          phase_nxt    = PH_SKIP;
          skip_cnt_nxt = 2'd2;
        end
      end
      PH_SKIP: begin
        skip_cnt_nxt = skip_cnt_r - 2'd1;
        if (skip_cnt_r == 2'd1) begin
          phase_nxt         = PH_SIZE;
          size_acc_nxt      = '0;
          digit_seen_nxt    = 1'b0;
          digits_closed_nxt = 1'b0;
          cr_pending_nxt    = 1'b0;
        end
      end
      default: ;
    endcase

    if (phase_nxt == PH_STOP) begin
      emit_status = stop_status_nxt;
    end else if (phase_nxt == PH_DATA) begin
      emit_status = ST_TRUNCATED;
    end else begin
      emit_status = ST_EARLY_END;
    end
  end

  assign emit = emit_dv || in_ch.last_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_SIZE;
      size_acc_r      <= '0;
      digit_seen_r    <= 1'b0;
      digits_closed_r <= 1'b0;
      cr_pending_r    <= 1'b0;
      bytes_rem_r     <= '0;
      skip_cnt_r      <= 2'd0;
      stop_status_r   <= ST_TERMINAL;
    end else if (in_fire) begin
      if (in_ch.last_in) begin
        phase_r         <= PH_SIZE;
        size_acc_r      <= '0;
        digit_seen_r    <= 1'b0;
        digits_closed_r <= 1'b0;
        cr_pending_r    <= 1'b0;
        bytes_rem_r     <= '0;
        skip_cnt_r      <= 2'd0;
        stop_status_r   <= ST_TERMINAL;
      end else begin
        phase_r         <= phase_nxt;
        size_acc_r      <= size_acc_nxt;
        digit_seen_r    <= digit_seen_nxt;
        digits_closed_r <= digits_closed_nxt;
        cr_pending_r    <= cr_pending_nxt;
        bytes_rem_r     <= bytes_rem_nxt;
        skip_cnt_r      <= skip_cnt_nxt;
        stop_status_r   <= stop_status_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_byte_r   <= emit_dv ? c : 8'd0;
      out_dv_r     <= emit_dv;
      out_eom_r    <= in_ch.last_in;
      out_status_r <= in_ch.last_in ? emit_status : ST_TERMINAL;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.byte_out       = out_byte_r;
  assign out_ch.data_valid     = out_dv_r;
  assign out_ch.end_of_message = out_eom_r;
  assign out_ch.end_status     = out_status_r;

`ifndef SYNTHESIS
  a_result_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data_valid || out_ch.end_of_message))
    else $error("result carries neither data nor end of message");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.end_of_message) |-> (out_ch.end_status == ST_TERMINAL))
    else $error("end status set on a result that is not the last");

  a_last_resets_parser: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.last_in) |=> (phase_r == PH_SIZE && bytes_rem_r == '0))
    else $error("parser not back in size line phase after last byte");

  a_data_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (bytes_rem_r != '0))
    else $error("data phase with no bytes remaining");

  a_skip_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP) |-> (skip_cnt_r == 2'd1 || skip_cnt_r == 2'd2))
    else $error("skip counter out of range in skip phase");
`endif

endmodule

`default_nettype wire
